@@ rtl/pmp_pkg.sv @@
// Package for the page mapper with protection: request/result payloads,
// configuration bundle, sequencer states and fixed codes.
// No dependencies.
package pmp_pkg;

    // Operation codes
    localparam logic [1:0] OP_TRANSLATE   = 2'd0;
    localparam logic [1:0] OP_TABLE_READ  = 2'd1;
    localparam logic [1:0] OP_TABLE_WRITE = 2'd2;

    // Table access sizes (size three behaves as long)
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;

    // Configuration register indexes and APB address width
    localparam logic [1:0] REG_MAP_DISABLE   = 2'd0;
    localparam logic [1:0] REG_JOB_BOOT_DONE = 2'd1;
    localparam logic [1:0] REG_DMA_BOOT_DONE = 2'd2;
    localparam int         APB_ADDR_W        = 4;

    // Entry word bit positions
    localparam int E1_NO_READ_BIT  = 15;
    localparam int E1_NO_WRITE_BIT = 14;
    localparam int E1_NO_EXEC_BIT  = 13;
    localparam int E0_REF_BIT      = 0;
    localparam int E0_DIRTY_BIT    = 1;
    localparam int FORCE_HIGH_BIT  = 23;

    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] address;
        logic        is_super;
        logic        is_data;
        logic        is_store;
        logic        is_code;
        logic        is_debug;
        logic        from_job_cpu;
        logic [1:0]  access_size;
        logic [31:0] write_value;
    } pmp_req_t;

    typedef struct packed {
        logic        fault;
        logic [23:0] physical_address;
        logic        may_read;
        logic        may_write;
        logic        may_exec;
        logic [31:0] read_value;
    } pmp_rsp_t;

    typedef struct packed {
        logic map_disable;
        logic job_boot_done;
        logic dma_boot_done;
    } pmp_cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } pmp_state_t;

endpackage

@@ rtl/pmp_if.sv @@
// Valid/ready channel interfaces for mapper requests and results.
// Depends on pmp_pkg.
interface pmp_req_if
    import pmp_pkg::*;
();
    logic     valid;
    logic     ready;
    pmp_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pmp_rsp_if
    import pmp_pkg::*;
();
    logic     valid;
    logic     ready;
    pmp_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pmp_ram.sv @@
// Generic single-clock RAM, one write port and one read port,
// read data registered. No dependencies.
module pmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pmp_cfg.sv @@
// APB configuration registers of the page mapper: mapping disable and
// boot-done flags of both CPUs. Depends on pmp_pkg.
module pmp_cfg
    import pmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output pmp_cfg_t              cfg
);

    pmp_cfg_t   cfg_reg;
    pmp_cfg_t   cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAP_DISABLE:   cfg_next.map_disable   = pwdata[0];
                REG_JOB_BOOT_DONE: cfg_next.job_boot_done = pwdata[0];
                REG_DMA_BOOT_DONE: cfg_next.dma_boot_done = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_MAP_DISABLE:   prdata[0] = cfg_reg.map_disable;
            REG_JOB_BOOT_DONE: prdata[0] = cfg_reg.job_boot_done;
            REG_DMA_BOOT_DONE: prdata[0] = cfg_reg.dma_boot_done;
            default: ;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/page_mapper_with_protection_unit.sv @@
// A request accepted in IDLE issues the table word reads; in EXEC the result is
// registered and output valid set once the output is free. A new request is taken
// only after EXEC ends, set by the read-then-write-back pass over the even/odd
// table word RAMs (read issued on accept, write in EXEC). Reset: sequencer, output
// valid and config registers clear; the table RAMs are not cleared and hold
// undefined data until written. Depends on pmp_pkg, pmp_if, pmp_ram and pmp_cfg.
module page_mapper_with_protection_unit
    import pmp_pkg::*;
#(
    parameter int PAGE_BITS  = 12,
    parameter int VPAGE_BITS = 11,
    parameter int FRAME_BITS = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pmp_req_if.sink               request,
    pmp_rsp_if.source             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int ROW_W  = VPAGE_BITS + 1;   // row of one bank (entry pair)
    localparam int ROWS   = 2 << VPAGE_BITS;
    localparam int WORD_W = VPAGE_BITS + 2;   // table word index

    pmp_cfg_t   cfg;
    pmp_state_t state_reg;
    pmp_state_t state_next;

    logic       req_fire;
    logic       exec_done;
    logic       out_valid_reg;
    logic       out_valid_next;
    pmp_rsp_t   rsp_reg;
    pmp_rsp_t   rsp_next;

    pmp_req_t   item_reg;
    logic [23:0] va_reg;
    logic [ROW_W-1:0] ev_addr_reg;
    logic [ROW_W-1:0] od_addr_reg;

    logic [23:0]       va_in;
    logic [31:0]       va_ext;
    logic [31:0]       page_full;
    logic [ROW_W-1:0]  tr_row;
    logic [WORD_W-1:0] tbl_word;
    logic [ROW_W-1:0]  tbl_row;
    logic [ROW_W-1:0]  ev_addr_in;
    logic [ROW_W-1:0]  od_addr_in;

    logic [15:0] ev_q;
    logic [15:0] od_q;
    logic        ev_wr;
    logic        od_wr;
    logic        ev_we;
    logic        od_we;
    logic [15:0] ev_wdata;
    logic [15:0] od_wdata;

    logic        bypass;
    logic        odd_word;
    logic        fault_r;
    logic        fault_w;
    logic        fault_x;
    logic [15:0] word_lo;
    logic [15:0] word_hi;
    logic [31:0] frame_ext;

    pmp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Even table words (word 2n) and odd table words (word 2n+1)
    pmp_ram #(.WIDTH(16), .DEPTH(ROWS)) u_ram_even (
        .clk   (clk),
        .we    (ev_we),
        .waddr (ev_addr_reg),
        .wdata (ev_wdata),
        .re    (req_fire),
        .raddr (ev_addr_in),
        .rdata (ev_q)
    );

    pmp_ram #(.WIDTH(16), .DEPTH(ROWS)) u_ram_odd (
        .clk   (clk),
        .we    (od_we),
        .waddr (od_addr_reg),
        .wdata (od_wdata),
        .re    (req_fire),
        .raddr (od_addr_in),
        .rdata (od_q)
    );

    // Address generation on accept: boot-mode forcing, entry row, table word rows
    always_comb
    begin
        va_in = request.data.address;
        if (request.data.from_job_cpu ? !cfg.job_boot_done : !cfg.dma_boot_done)
        begin
            va_in[FORCE_HIGH_BIT] = 1'b1;
        end
        va_ext    = {8'd0, va_in};
        page_full = va_ext >> PAGE_BITS;
        tr_row    = {request.data.is_super, page_full[VPAGE_BITS-1:0]};
        tbl_word  = request.data.address[WORD_W:1];
        tbl_row   = tbl_word[WORD_W-1:1];
        if (request.data.operation == OP_TRANSLATE)
        begin
            ev_addr_in = tr_row;
            od_addr_in = tr_row;
        end
        else
        begin
            // odd start word: its successor sits in the next even row
            ev_addr_in = tbl_word[0] ? tbl_row + ROW_W'(1) : tbl_row;
            od_addr_in = tbl_row;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_fire)  state_next = ST_EXEC;
            ST_EXEC: if (exec_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        request.ready = (state_reg == ST_IDLE);
        exec_done     = (state_reg == ST_EXEC) && (!out_valid_reg || result.ready);
    end

    assign req_fire = request.valid && request.ready;

    // Result and write-back datapath, evaluated in EXEC
    always_comb
    begin
        rsp_next  = '0;
        ev_wr     = 1'b0;
        od_wr     = 1'b0;
        ev_wdata  = ev_q;
        od_wdata  = od_q;
        bypass    = cfg.map_disable | va_reg[FORCE_HIGH_BIT];
        odd_word  = item_reg.address[1];
        fault_r   = od_q[E1_NO_READ_BIT] & item_reg.is_data & !item_reg.is_store &
                    !item_reg.is_code;
        fault_w   = od_q[E1_NO_WRITE_BIT] & item_reg.is_store;
        fault_x   = od_q[E1_NO_EXEC_BIT] & item_reg.is_code;
        word_lo   = odd_word ? od_q : ev_q;    // word at the offset
        word_hi   = odd_word ? ev_q : od_q;    // following word
        frame_ext = 32'(od_q[FRAME_BITS-1:0]) << PAGE_BITS;

        unique case (item_reg.operation)
            OP_TRANSLATE:
            begin
                if (bypass)
                begin
                    if (!item_reg.is_super)
                    begin
                        rsp_next.fault = 1'b1;
                    end
                    else
                    begin
                        rsp_next.physical_address = va_reg;
                        rsp_next.may_read         = 1'b1;
                        rsp_next.may_write        = 1'b1;
                        rsp_next.may_exec         = 1'b1;
                    end
                end
                else if (fault_r | fault_w | fault_x)
                begin
                    rsp_next.fault = 1'b1;
                end
                else
                begin
                    rsp_next.physical_address = frame_ext[23:0];
                    rsp_next.may_read         = !od_q[E1_NO_READ_BIT];
                    rsp_next.may_write        = !od_q[E1_NO_WRITE_BIT] & item_reg.is_store;
                    rsp_next.may_exec         = !od_q[E1_NO_EXEC_BIT];
                    // mark referenced, and dirty on a store
                    ev_wdata[E0_REF_BIT]   = 1'b1;
                    ev_wdata[E0_DIRTY_BIT] = ev_q[E0_DIRTY_BIT] | item_reg.is_store;
                    ev_wr = !item_reg.is_debug;
                end
            end
            OP_TABLE_READ:
            begin
                unique case (item_reg.access_size)
                    SZ_WORD: rsp_next.read_value = 32'(word_lo);
                    SZ_BYTE: rsp_next.read_value = item_reg.address[0] ?
                                                   32'(word_lo[7:0]) : 32'(word_lo[15:8]);
                    default: rsp_next.read_value = {word_lo, word_hi};
                endcase
            end
            OP_TABLE_WRITE:
            begin
                unique case (item_reg.access_size)
                    SZ_BYTE:
                    begin
                        rsp_next.fault = 1'b1;
                    end
                    SZ_WORD:
                    begin
                        ev_wdata = item_reg.write_value[15:0];
                        od_wdata = item_reg.write_value[15:0];
                        ev_wr    = !odd_word;
                        od_wr    = odd_word;
                    end
                    default:
                    begin
                        // high half to the offset word, low half to the next
                        ev_wdata = odd_word ? item_reg.write_value[15:0] :
                                              item_reg.write_value[31:16];
                        od_wdata = odd_word ? item_reg.write_value[31:16] :
                                              item_reg.write_value[15:0];
                        ev_wr    = 1'b1;
                        od_wr    = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign ev_we = exec_done & ev_wr;
    assign od_we = exec_done & od_wr;

    // Output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg & !result.ready;
        if (exec_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg    <= request.data;
            va_reg      <= va_in;
            ev_addr_reg <= ev_addr_in;
            od_addr_reg <= od_addr_in;
        end
        if (exec_done)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = rsp_reg;

    // Table writes happen only while an item is being finished
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_we || od_we) |-> exec_done)
        else $error("table write outside EXEC");

    // An accepted item always moves to EXEC
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter EXEC");

    // A finished item always shows up at the output
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        exec_done |=> out_valid_reg)
        else $error("finished item lost");

    // Debug translations never update the table
    a_debug_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && (item_reg.operation == OP_TRANSLATE) &&
         item_reg.is_debug) |-> !(ev_we || od_we))
        else $error("debug translation wrote the table");

    // Byte table writes fault and never update the table
    a_byte_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && (item_reg.operation == OP_TABLE_WRITE) &&
         (item_reg.access_size == SZ_BYTE)) |-> (!(ev_we || od_we) && rsp_next.fault))
        else $error("byte table write not refused");

endmodule
